FILE: rtl/fcr_pkg.sv
// Shared types and constants of the framed command receiver.
// Used by the front, the queue, the back and the top level.
package fcr_pkg;

	localparam int MAX_FRAME_WORDS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam logic [15:0] SYNC_FIRST  = 16'hAAAA;
	localparam logic [15:0] SYNC_SECOND = 16'h5555;
	localparam logic [15:0] SYNC_SUM    = 16'hFFFF;
	localparam logic [15:0] REPLY_BASE  = 16'h0006;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLY_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAK_CODE   = 2'd2;

	typedef enum logic [2:0] {
		VD_ACK_CMD   = 3'd0,
		VD_REQUEST   = 3'd1,
		VD_QUEUE_FULL = 3'd2,
		VD_UNKNOWN   = 3'd3,
		VD_CHK_BAD   = 3'd4,
		VD_OVERLEN   = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] seq_number;
		logic [7:0]  command_byte;
		logic [15:0] param_index;
		logic [15:0] param_low;
		logic [15:0] param_high;
		logic [15:0] computed_sum;
	} rec_t;

endpackage

FILE: rtl/fcr_front.sv
// Front part: sync hunt, frame collection, running sum and verdict.
// Depends on fcr_pkg; pushes one record per finished frame.
module fcr_front import fcr_pkg::*; #(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [15:0] word,
	input  logic        queue_full,
	output logic        push,
	output rec_t        rec
);

	localparam int CW = $clog2(MAX_FRAME_WORDS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_WORDS);
	localparam logic [CW-1:0] CNT_TWO = CW'(2);

	typedef enum logic [1:0] {
		HUNT_FIRST  = 2'd0,
		HUNT_SECOND = 2'd1,
		COLLECT     = 2'd2
	} phase_t;

	phase_t      phase_q;
	logic [CW-1:0] count_q;
	logic [15:0] len_q, sum_q, seq_q, idx_q, lo_q, hi_q;
	logic [7:0]  cmd_q;

	logic [CW-1:0] count_n;
	logic [15:0] len_n, seq_n, idx_n, lo_n, hi_n;
	logic [7:0]  cmd_n;
	logic        frame_end;
	verdict_t    vd;

	always_comb begin
		len_n = (count_q == CW'(2)) ? word : len_q;
		seq_n = (count_q == CW'(3)) ? word : seq_q;
		cmd_n = (count_q == CW'(4)) ? word[7:0] : cmd_q;
		idx_n = (count_q == CW'(5)) ? word : idx_q;
		lo_n  = (count_q == CW'(6)) ? word : lo_q;
		hi_n  = (count_q == CW'(7)) ? word : hi_q;
		count_n = count_q + CW'(1);
		frame_end = !((16'(count_n) < len_n) && (count_n < CNT_MAX));
		if (16'(count_n) < len_n) begin
			vd = VD_OVERLEN;
		end else if (sum_q != word) begin
			vd = VD_CHK_BAD;
		end else if (cmd_n[4:0] != 5'd0) begin
			vd = queue_full ? VD_QUEUE_FULL : VD_ACK_CMD;
		end else if (cmd_n[7:5] != 3'd0) begin
			vd = VD_REQUEST;
		end else begin
			vd = VD_UNKNOWN;
		end
	end

	assign push = take && (phase_q == COLLECT) && frame_end;

	always_comb begin
		rec.verdict      = vd;
		rec.seq_number   = seq_n;
		rec.command_byte = cmd_n;
		rec.param_index  = idx_n;
		rec.param_low    = lo_n;
		rec.param_high   = hi_n;
		rec.computed_sum = sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT_FIRST;
			count_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			seq_q   <= '0;
			cmd_q   <= '0;
			idx_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else if (take) begin
			case (phase_q)
				HUNT_SECOND: begin
					if (word == SYNC_SECOND) begin
						phase_q <= COLLECT;
						count_q <= CNT_TWO;
						sum_q   <= SYNC_SUM;
						len_q   <= '0;
						seq_q   <= '0;
						cmd_q   <= '0;
						idx_q   <= '0;
						lo_q    <= '0;
						hi_q    <= '0;
					end else begin
						phase_q <= HUNT_FIRST;
					end
				end
				COLLECT: begin
					if (frame_end) begin
						phase_q <= HUNT_FIRST;
						count_q <= '0;
						len_q   <= '0;
						sum_q   <= '0;
						seq_q   <= '0;
						cmd_q   <= '0;
						idx_q   <= '0;
						lo_q    <= '0;
						hi_q    <= '0;
					end else begin
						count_q <= count_n;
						sum_q   <= sum_q + word;
						len_q   <= len_n;
						seq_q   <= seq_n;
						cmd_q   <= cmd_n;
						idx_q   <= idx_n;
						lo_q    <= lo_n;
						hi_q    <= hi_n;
					end
				end
				default: begin
					phase_q <= (word == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
				end
			endcase
		end
	end

endmodule

FILE: rtl/fcr_queue.sv
// Short record queue between the front and the back part.
// Depends on fcr_pkg for the record type.
module fcr_queue import fcr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wdata,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output rec_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	rec_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] fill_q;

	assign full     = (fill_q == NW'(DEPTH));
	assign nonempty = (fill_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

FILE: rtl/fcr_back.sv
// Back part: reply checksum and the verdict output register.
// Depends on fcr_pkg; reads records from fcr_queue.
module fcr_back import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  rec_t        q_rec,
	output logic        q_pop,
	input  logic [15:0] reply_type_q,
	input  logic [15:0] ack_code_q,
	input  logic [15:0] nak_code_q,
	output logic        verdict_valid,
	input  logic        verdict_ready,
	output rec_t        out_rec,
	output logic [15:0] reply_checksum
);

	logic        valid_q;
	rec_t        rec_q;
	logic [15:0] chk_q;
	logic [15:0] code;
	logic [15:0] chk_n;

	always_comb begin
		case (q_rec.verdict)
			VD_ACK_CMD: code = ack_code_q;
			default:    code = nak_code_q;
		endcase
		if (q_rec.verdict == VD_REQUEST) begin
			chk_n = '0;
		end else begin
			chk_n = REPLY_BASE + q_rec.seq_number + reply_type_q + code;
		end
	end

	assign q_pop          = q_nonempty && (!valid_q || verdict_ready);
	assign verdict_valid  = valid_q;
	assign out_rec        = rec_q;
	assign reply_checksum = chk_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
			chk_q <= chk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (verdict_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/framed_command_receiver_top.sv
// Framed command receiver: one link word per cycle unless stalled; one verdict per frame.
// Path: a frame's record is written into the record queue when its last word is taken, then into the output register.
// Throughput: one word per cycle; word_ready drops only when the record queue is full.
// Reset: asynchronous, hunts for the first sync word, registers to defaults.
// Depends on fcr_pkg, fcr_front, fcr_queue and fcr_back.
module framed_command_receiver_top import fcr_pkg::*; #(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 word_valid,
	output logic                 word_ready,
	input  logic [15:0]          word,
	input  logic                 queue_full,
	output logic                 verdict_valid,
	input  logic                 verdict_ready,
	output logic [2:0]           verdict,
	output logic [15:0]          seq_number,
	output logic [7:0]           command_byte,
	output logic [15:0]          param_index,
	output logic [15:0]          param_low,
	output logic [15:0]          param_high,
	output logic [15:0]          computed_sum,
	output logic [15:0]          reply_checksum
);

	logic [15:0] reply_type_q, ack_code_q, nak_code_q;
	logic        take, push, q_full, q_nonempty, q_pop;
	rec_t        f_rec, q_rec, out_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_type_q <= 16'd0;
			ack_code_q   <= 16'd0;
			nak_code_q   <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPLY_TYPE: reply_type_q <= cfg_data;
				REG_ACK_CODE:   ack_code_q   <= cfg_data;
				REG_NAK_CODE:   nak_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign word_ready = !q_full;
	assign take       = word_valid && !q_full;

	fcr_front #(
		.MAX_FRAME_WORDS(MAX_FRAME_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.word       (word),
		.queue_full (queue_full),
		.push       (push),
		.rec        (f_rec)
	);

	fcr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (f_rec),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rdata    (q_rec)
	);

	fcr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.q_rec          (q_rec),
		.q_pop          (q_pop),
		.reply_type_q   (reply_type_q),
		.ack_code_q     (ack_code_q),
		.nak_code_q     (nak_code_q),
		.verdict_valid  (verdict_valid),
		.verdict_ready  (verdict_ready),
		.out_rec        (out_rec),
		.reply_checksum (reply_checksum)
	);

	assign verdict      = out_rec.verdict;
	assign seq_number   = out_rec.seq_number;
	assign command_byte = out_rec.command_byte;
	assign param_index  = out_rec.param_index;
	assign param_low    = out_rec.param_low;
	assign param_high   = out_rec.param_high;
	assign computed_sum = out_rec.computed_sum;

endmodule
